// ===== rtl/lr_pkg.sv =====
package lr_pkg;

    // Item kinds on the command channel.
    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

endpackage

// ===== rtl/lr_cmd_if.sv =====
interface lr_cmd_if
    import lr_pkg::*;
#(
    parameter int COLS = 128,
    parameter int ROWS = 32
);
    localparam int XW = $clog2(COLS);
    localparam int YW = $clog2(ROWS);

    logic          valid;
    logic          ready;
    kind_t         kind;
    logic [XW-1:0] first_x;
    logic [YW-1:0] first_y;
    logic [XW-1:0] second_x;
    logic [YW-1:0] second_y;

    modport source (output valid, kind, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, kind, first_x, first_y, second_x, second_y, output ready);

endinterface

// ===== rtl/lr_pix_if.sv =====
interface lr_pix_if
#(
    parameter int COLS = 128,
    parameter int ROWS = 32
);
    localparam int XW = $clog2(COLS);
    localparam int YW = $clog2(ROWS);

    logic          valid;
    logic          ready;
    logic [XW-1:0] pixel_x;
    logic [YW-1:0] pixel_y;
    logic          last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);

endinterface

// ===== rtl/line_rasterizer_top.sv =====
// Bresenham line engine: a start item loads two endpoints, each step item on a busy line yields the next pixel.
// A pixel appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the error-term add and compare are combinational.
// A stalled output register holds its pixel and blocks new items until it is taken.
// Reset clears the busy flag and the output valid; the line registers load on start.
module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int COLS = 128,
    parameter int ROWS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    lr_cmd_if.sink   cmd,
    lr_pix_if.source pix
);

    localparam int XW = $clog2(COLS);
    localparam int YW = $clog2(ROWS);
    localparam int MW = (XW > YW) ? XW : YW;
    localparam int DW = MW + 2;

    // Line state.
    logic                 busy_reg, busy_next;
    logic [XW-1:0]        cur_x_reg, cur_x_next;
    logic [YW-1:0]        cur_y_reg, cur_y_next;
    logic [MW-1:0]        major_end_reg, major_end_next;
    logic [XW-1:0]        span_x_reg, span_x_next;
    logic [YW-1:0]        span_y_reg, span_y_next;
    logic                 steep_reg, steep_next;
    logic                 minor_down_reg, minor_down_next;
    logic signed [DW-1:0] decision_reg, decision_next;

    // Output register.
    logic                 pix_valid_reg, pix_valid_next;
    logic [XW-1:0]        pix_x_reg, pix_x_next;
    logic [YW-1:0]        pix_y_reg, pix_y_next;
    logic                 pix_last_reg, pix_last_next;

    logic                 accept;
    logic                 emit;

    // Start path signals.
    logic [XW-1:0]        ax, bx, sx, ex;
    logic [YW-1:0]        ay, by, sy, ey;
    logic [XW-1:0]        dx;
    logic [YW-1:0]        dy;
    logic                 st_steep;
    logic                 st_swap;
    logic                 st_last;

    // Step path signals.
    logic [MW-1:0]        major_span, minor_span, major_now, minor_now;
    logic [MW-1:0]        minor_new;
    logic                 sp_last;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !pix_valid_reg || pix.ready;

    assign pix.valid   = pix_valid_reg;
    assign pix.pixel_x = pix_x_reg;
    assign pix.pixel_y = pix_y_reg;
    assign pix.last    = pix_last_reg;

    // Clamp endpoints to the raster and order them along the major axis.
    always_comb
    begin
        ax = ({1'b0, cmd.first_x}  >= (XW+1)'(COLS)) ? XW'(COLS - 1) : cmd.first_x;
        bx = ({1'b0, cmd.second_x} >= (XW+1)'(COLS)) ? XW'(COLS - 1) : cmd.second_x;
        ay = ({1'b0, cmd.first_y}  >= (YW+1)'(ROWS)) ? YW'(ROWS - 1) : cmd.first_y;
        by = ({1'b0, cmd.second_y} >= (YW+1)'(ROWS)) ? YW'(ROWS - 1) : cmd.second_y;

        dx = (ax > bx) ? (ax - bx) : (bx - ax);
        dy = (ay > by) ? (ay - by) : (by - ay);
        st_steep = MW'(dy) > MW'(dx);
        st_swap  = st_steep ? (ay > by) : (ax > bx);

        if (st_swap)
        begin
            sx = bx; sy = by; ex = ax; ey = ay;
        end
        else
        begin
            sx = ax; sy = ay; ex = bx; ey = by;
        end
        st_last = st_steep ? (sy == ey) : (sx == ex);
    end

    // One Bresenham step from the current pixel.
    always_comb
    begin
        major_span = steep_reg ? MW'(span_y_reg) : MW'(span_x_reg);
        minor_span = steep_reg ? MW'(span_x_reg) : MW'(span_y_reg);
        major_now  = (steep_reg ? MW'(cur_y_reg) : MW'(cur_x_reg)) + MW'(1);
        minor_now  = steep_reg ? MW'(cur_x_reg) : MW'(cur_y_reg);
        sp_last    = (major_now == major_end_reg);
    end

    // Next-state selection for start and step items.
    always_comb
    begin
        busy_next       = busy_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        major_end_next  = major_end_reg;
        span_x_next     = span_x_reg;
        span_y_next     = span_y_reg;
        steep_next      = steep_reg;
        minor_down_next = minor_down_reg;
        decision_next   = decision_reg;
        minor_new       = minor_now;
        emit            = 1'b0;
        pix_last_next   = 1'b0;

        if (accept)
        begin
            unique case (cmd.kind)
                KIND_START:
                begin
                    emit            = 1'b1;
                    cur_x_next      = sx;
                    cur_y_next      = sy;
                    span_x_next     = dx;
                    span_y_next     = dy;
                    steep_next      = st_steep;
                    busy_next       = !st_last;
                    pix_last_next   = st_last;
                    if (st_steep)
                    begin
                        major_end_next  = MW'(ey);
                        minor_down_next = (ex < sx);
                        decision_next   = $signed({(DW-1)'(dx), 1'b0}) - $signed(DW'(dy));
                    end
                    else
                    begin
                        major_end_next  = MW'(ex);
                        minor_down_next = (ey < sy);
                        decision_next   = $signed({(DW-1)'(dy), 1'b0}) - $signed(DW'(dx));
                    end
                end
                KIND_STEP:
                begin
                    if (busy_reg)
                    begin
                        emit = 1'b1;
                        if (decision_reg < 0)
                        begin
                            decision_next = decision_reg
                                          + $signed({(DW-1)'(minor_span), 1'b0});
                        end
                        else
                        begin
                            minor_new     = minor_down_reg ? (minor_now - MW'(1))
                                                           : (minor_now + MW'(1));
                            decision_next = decision_reg
                                          + $signed({(DW-1)'(minor_span), 1'b0})
                                          - $signed({(DW-1)'(major_span), 1'b0});
                        end
                        if (steep_reg)
                        begin
                            cur_y_next = major_now[YW-1:0];
                            cur_x_next = minor_new[XW-1:0];
                        end
                        else
                        begin
                            cur_x_next = major_now[XW-1:0];
                            cur_y_next = minor_new[YW-1:0];
                        end
                        pix_last_next = sp_last;
                        busy_next     = !sp_last;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        pix_x_next     = cur_x_next;
        pix_y_next     = cur_y_next;
        pix_valid_next = emit ? 1'b1 : (pix_valid_reg && !pix.ready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Line and pixel registers.
    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        major_end_reg  <= major_end_next;
        span_x_reg     <= span_x_next;
        span_y_reg     <= span_y_next;
        steep_reg      <= steep_next;
        minor_down_reg <= minor_down_next;
        decision_reg   <= decision_next;
        if (emit)
        begin
            pix_x_reg    <= pix_x_next;
            pix_y_reg    <= pix_y_next;
            pix_last_reg <= pix_last_next;
        end
    end

endmodule

// ===== rtl/lr_checker.sv =====
module lr_checker
    import lr_pkg::*;
#(
    parameter int XW = 7,
    parameter int YW = 5
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input kind_t         cmd_kind,
    input logic [XW-1:0] cmd_first_x,
    input logic [YW-1:0] cmd_first_y,
    input logic [XW-1:0] cmd_second_x,
    input logic [YW-1:0] cmd_second_y,
    input logic          pix_valid,
    input logic          pix_ready,
    input logic [XW-1:0] pix_x,
    input logic [YW-1:0] pix_y,
    input logic          pix_last
);

    // A stalled pixel keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_x) && $stable(pix_y)
                                    && $stable(pix_last))
        else $error("stalled pixel changed");

    // No item is taken while a pixel waits downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |-> !cmd_ready)
        else $error("item accepted while output stalled");

    // Every start yields a pixel in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_kind == KIND_START |=> pix_valid)
        else $error("start produced no pixel");

    // A line with coincident endpoints is a single last pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_kind == KIND_START
        && cmd_first_x == cmd_second_x && cmd_first_y == cmd_second_y
        |=> pix_last && pix_x == $past(cmd_first_x) && pix_y == $past(cmd_first_y))
        else $error("single-point line not flagged last");

endmodule

bind line_rasterizer_top lr_checker
#(
    .XW($clog2(COLS)),
    .YW($clog2(ROWS))
)
u_lr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_kind     (cmd.kind),
    .cmd_first_x  (cmd.first_x),
    .cmd_first_y  (cmd.first_y),
    .cmd_second_x (cmd.second_x),
    .cmd_second_y (cmd.second_y),
    .pix_valid    (pix.valid),
    .pix_ready    (pix.ready),
    .pix_x        (pix.pixel_x),
    .pix_y        (pix.pixel_y),
    .pix_last     (pix.last)
);

// ===== tb/sv/tb_line_rasterizer_top.sv =====
module tb_line_rasterizer_top;
    import lr_pkg::*;

    localparam int COLS = 128;
    localparam int ROWS = 32;
    localparam int XW   = $clog2(COLS);
    localparam int YW   = $clog2(ROWS);

    // One item on the command channel.
    typedef struct packed
    {
        kind_t         kind;
        logic [XW-1:0] first_x;
        logic [YW-1:0] first_y;
        logic [XW-1:0] second_x;
        logic [YW-1:0] second_y;
    } line_cmd_t;

    // One pixel on the output channel.
    typedef struct packed
    {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic          last;
    } pixel_t;

    logic clk;
    logic rst_n;

    lr_cmd_if #(.COLS(COLS), .ROWS(ROWS)) cmd_bus ();
    lr_pix_if #(.COLS(COLS), .ROWS(ROWS)) pix_bus ();

    line_rasterizer_top #(.COLS(COLS), .ROWS(ROWS)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus)
    );

    // Items waiting to be sent and pixels waiting to be seen.
    line_cmd_t cmd_pending[$];
    pixel_t    pixels_due[$];

    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  cmd_fire;
    int  fail_count;
    int  lines_started;
    int  lines_restarted;
    int  step_items;
    int  idle_steps;
    int  pixels_checked;
    int  ends_checked;

    // Shadow copy of the line engine.
    bit                ln_busy;
    logic [XW-1:0]     ln_cur_x;
    logic [YW-1:0]     ln_cur_y;
    logic [XW-1:0]     ln_major_end;
    logic [XW-1:0]     ln_span_x;
    logic [XW-1:0]     ln_span_y;
    bit                ln_steep;
    bit                ln_minor_down;
    logic signed [9:0] ln_err;

    // Advances the shadow engine by one item; returns 1 when a pixel comes out.
    function automatic bit trace_pixel(input line_cmd_t c, output pixel_t px);
        int ax, ay, bx, by, sx, sy, ex, ey;
        int maj_span, min_span, maj_now, min_now, err;
        bit at_end;
        px = '0;
        if (c.kind == KIND_START)
        begin
            ax = (c.first_x >= COLS) ? COLS - 1 : c.first_x;
            ay = (c.first_y >= ROWS) ? ROWS - 1 : c.first_y;
            bx = (c.second_x >= COLS) ? COLS - 1 : c.second_x;
            by = (c.second_y >= ROWS) ? ROWS - 1 : c.second_y;
            ln_span_x = XW'((ax > bx) ? ax - bx : bx - ax);
            ln_span_y = XW'((ay > by) ? ay - by : by - ay);
            ln_steep  = ln_span_y > ln_span_x;
            // Drawing starts at the endpoint with the smaller major coordinate.
            if ((!ln_steep && ax > bx) || (ln_steep && ay > by))
            begin
                sx = bx; sy = by; ex = ax; ey = ay;
            end
            else
            begin
                sx = ax; sy = ay; ex = bx; ey = by;
            end
            ln_cur_x = XW'(sx);
            ln_cur_y = YW'(sy);
            if (ln_steep)
            begin
                ln_major_end  = XW'(ey);
                ln_minor_down = ex < sx;
                err           = 2 * int'(ln_span_x) - int'(ln_span_y);
                at_end        = (sy == ey);
            end
            else
            begin
                ln_major_end  = XW'(ex);
                ln_minor_down = ey < sy;
                err           = 2 * int'(ln_span_y) - int'(ln_span_x);
                at_end        = (sx == ex);
            end
            ln_err  = err[9:0];
            ln_busy = !at_end;
        end
        else
        begin
            if (!ln_busy)
                return 0;
            maj_span = ln_steep ? int'(ln_span_y) : int'(ln_span_x);
            min_span = ln_steep ? int'(ln_span_x) : int'(ln_span_y);
            maj_now  = (ln_steep ? int'(ln_cur_y) : int'(ln_cur_x)) + 1;
            min_now  = ln_steep ? int'(ln_cur_x) : int'(ln_cur_y);
            err      = ln_err;
            // Error term decides whether the minor axis moves on this pixel.
            if (ln_err < 0)
                err += 2 * min_span;
            else
            begin
                min_now = ln_minor_down ? min_now - 1 : min_now + 1;
                err += 2 * (min_span - maj_span);
            end
            ln_err = err[9:0];
            if (ln_steep)
            begin
                ln_cur_y = maj_now[YW-1:0];
                ln_cur_x = min_now[XW-1:0];
                at_end   = (ln_cur_y == ln_major_end);
            end
            else
            begin
                ln_cur_x = maj_now[XW-1:0];
                ln_cur_y = min_now[YW-1:0];
                at_end   = (ln_cur_x == ln_major_end);
            end
            if (at_end)
                ln_busy = 1'b0;
        end
        px.x    = ln_cur_x;
        px.y    = ln_cur_y;
        px.last = at_end;
        return 1;
    endfunction

    // Queues an item of the given kind with random endpoint fields.
    function automatic void push_item(input kind_t k);
        line_cmd_t c;
        c.kind     = k;
        c.first_x  = XW'($urandom);
        c.first_y  = YW'($urandom);
        c.second_x = XW'($urandom);
        c.second_y = YW'($urandom);
        cmd_pending.push_back(c);
    endfunction

    function automatic void push_start(input int ax, input int ay, input int bx, input int by);
        line_cmd_t c;
        c.kind     = KIND_START;
        c.first_x  = XW'(ax);
        c.first_y  = YW'(ay);
        c.second_x = XW'(bx);
        c.second_y = YW'(by);
        cmd_pending.push_back(c);
    endfunction

    // A coordinate within 8 of base, kept on the screen.
    function automatic int near_coord(input int base, input int limit);
        int v;
        v = base + int'($urandom_range(16)) - 8;
        if (v < 0)
            v = 0;
        if (v > limit - 1)
            v = limit - 1;
        return v;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Command driver: holds an item until it is taken, idles at random between items.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_fire && cmd_pending.size() != 0)
                void'(cmd_pending.pop_front());
            if (!cmd_bus.valid || cmd_fire)
            begin
                if (cmd_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    cmd_bus.valid    <= 1'b1;
                    cmd_bus.kind     <= cmd_pending[0].kind;
                    cmd_bus.first_x  <= cmd_pending[0].first_x;
                    cmd_bus.first_y  <= cmd_pending[0].first_y;
                    cmd_bus.second_x <= cmd_pending[0].second_x;
                    cmd_bus.second_y <= cmd_pending[0].second_y;
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
            pix_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: predicts pixels for accepted items and checks pixels that come out.
    always @(posedge clk)
    begin : monitor
        line_cmd_t got;
        pixel_t    predicted;
        pixel_t    seen;
        pixel_t    want;
        cmd_fire <= rst_n && cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1;
        if (rst_n && cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1)
        begin
            got.kind     = cmd_bus.kind;
            got.first_x  = cmd_bus.first_x;
            got.first_y  = cmd_bus.first_y;
            got.second_x = cmd_bus.second_x;
            got.second_y = cmd_bus.second_y;
            if (got.kind == KIND_START)
            begin
                lines_started++;
                if (ln_busy)
                    lines_restarted++;
            end
            else
            begin
                step_items++;
                if (!ln_busy)
                    idle_steps++;
            end
            if (trace_pixel(got, predicted))
                pixels_due.push_back(predicted);
        end
        if (rst_n && pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1)
        begin
            seen.x    = pix_bus.pixel_x;
            seen.y    = pix_bus.pixel_y;
            seen.last = pix_bus.last;
            if (pixels_due.size() == 0)
            begin
                $error("pixel (%0d,%0d) last=%0d with none expected", seen.x, seen.y, seen.last);
                fail_count++;
            end
            else
            begin
                want = pixels_due.pop_front();
                pixels_checked++;
                if (want.last)
                    ends_checked++;
                if (seen.x !== want.x)
                begin
                    $error("pixel_x expected %0d got %0d", want.x, seen.x);
                    fail_count++;
                end
                if (seen.y !== want.y)
                begin
                    $error("pixel_y expected %0d got %0d", want.y, seen.y);
                    fail_count++;
                end
                if (seen.last !== want.last)
                begin
                    $error("last expected %0d got %0d", want.last, seen.last);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus and run sequencing.
    initial
    begin
        int budget;
        int pick;
        int n;
        int ax, ay, bx, by;
        int span;
        cmd_bus.valid    = 1'b0;
        cmd_bus.kind     = KIND_START;
        cmd_bus.first_x  = '0;
        cmd_bus.first_y  = '0;
        cmd_bus.second_x = '0;
        cmd_bus.second_y = '0;
        pix_bus.ready    = 1'b0;
        cmd_fire         = 1'b0;
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        fail_count       = 0;
        lines_started    = 0;
        lines_restarted  = 0;
        step_items       = 0;
        idle_steps       = 0;
        pixels_checked   = 0;
        ends_checked     = 0;
        ln_busy          = 1'b0;
        ln_cur_x         = '0;
        ln_cur_y         = '0;
        ln_major_end     = '0;
        ln_span_x        = '0;
        ln_span_y        = '0;
        ln_steep         = 1'b0;
        ln_minor_down    = 1'b0;
        ln_err           = '0;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 86;
                end
                1:
                begin
                    tx_idle_pct  = 86;
                    rx_stall_pct = 10;
                end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                // Step with no line in progress, then single-point lines at both corners.
                push_item(KIND_STEP);
                push_start(0, 0, 0, 0);
                push_start(COLS - 1, ROWS - 1, COLS - 1, ROWS - 1);
                push_item(KIND_STEP);
                // Full-screen diagonal, cut short by a restart along the reversed line.
                push_start(0, 0, COLS - 1, ROWS - 1);
                repeat (2) push_item(KIND_STEP);
                push_start(COLS - 1, ROWS - 1, 0, 0);
                push_item(KIND_STEP);
                // Steep line with the minor axis running down.
                push_start(3, 0, 0, 6);
                repeat (6) push_item(KIND_STEP);
                // Equal spans, x taken as major, minor axis running down.
                push_start(0, 4, 4, 0);
                repeat (4) push_item(KIND_STEP);
                // Vertical line drawn from its lower row.
                push_start(10, 8, 10, 5);
                repeat (3) push_item(KIND_STEP);
            end

            // Mostly complete lines with random endpoints, some cut short, some noise.
            budget = 435;
            while (budget > 0)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                begin
                    n = $urandom_range(3, 1);
                    repeat (n) push_item($urandom_range(1) ? KIND_STEP : KIND_START);
                    budget -= n;
                end
                else
                begin
                    ax = $urandom_range(COLS - 1);
                    ay = $urandom_range(ROWS - 1);
                    if ($urandom_range(99) < 8)
                    begin
                        bx = $urandom_range(COLS - 1);
                        by = $urandom_range(ROWS - 1);
                    end
                    else
                    begin
                        bx = near_coord(ax, COLS);
                        by = near_coord(ay, ROWS);
                    end
                    push_start(ax, ay, bx, by);
                    span = (ax > bx) ? ax - bx : bx - ax;
                    if (((ay > by) ? ay - by : by - ay) > span)
                        span = (ay > by) ? ay - by : by - ay;
                    if (pick < 24 && span > 0)
                        n = $urandom_range(span - 1);
                    else
                        n = span;
                    repeat (n) push_item(KIND_STEP);
                    budget -= 1 + n;
                    // Up to two step items after the line has ended.
                    if (n == span)
                        repeat ($urandom_range(2)) push_item(KIND_STEP);
                end
            end

            // The sender stays quiet until every pixel of this part has come out.
            while (cmd_pending.size() != 0 || pixels_due.size() != 0)
                @(posedge clk);
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d line starts (%0d restarted a busy line) and %0d step items (%0d idle).",
                 lines_started, lines_restarted, step_items, idle_steps);
        $display("Checked %0d pixels, %0d of them line ends.", pixels_checked, ends_checked);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
